// ----- rtl/core/ncpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-centre pixel quantiser package
// Sizes, request codes, the candidate record that moves through the
// comparator tree, and the compare-and-select step used by every tree node.
// ----------------------------------------------------------------------------
package ncpq_pkg;

	localparam int MaxCenters  = 16;
	localparam int NumChannels = 3;
	localparam int ChannelBits = 8;
	localparam int IdxBits     = $clog2(MaxCenters);
	localparam int CfgBits     = 5;
	localparam int SqBits      = 2 * ChannelBits;
	localparam int DistBits    = 18;
	localparam int DistMax     = NumChannels * ((1 << ChannelBits) - 1) * ((1 << ChannelBits) - 1);

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_type_t;

	typedef logic [ChannelBits-1:0] chan_t;
	typedef chan_t [NumChannels-1:0] pix_t;

	// One centre as it competes in the tree. The centre colour is not carried;
	// it is rebuilt from the pixel, the absolute differences and their signs.
	typedef struct packed {
		logic                   act;
		logic [DistBits-1:0]    sq_dist;
		logic [IdxBits-1:0]     idx;
		pix_t                   diff;
		logic [NumChannels-1:0] neg;
	} cand_t;

	// The lower-index candidate keeps the place unless the other one is
	// active and strictly nearer, which gives ties to the lowest index.
	function automatic cand_t pick_nearer(cand_t lo, cand_t hi);
		cand_t r;
		r = (hi.act && (hi.sq_dist < lo.sq_dist)) ? hi : lo;
		r.act = lo.act | hi.act;
		return r;
	endfunction

endpackage

// ----- rtl/core/nearest_center_pixel_quantizer_top.sv -----
// A pixel request is registered through stages s1 to s5 before its result appears on the output.
// One request per clock while the output is not stalled; a load request gives no result.
// The pipeline has five register stages: difference, square, sum, and two stages of
// the 16-way minimum tree with two comparator levels each.
// Reset clears the pipeline valid bits and sets num_centers to 16; the centre store
// is not cleared and holds no valid data until loaded.
// ----------------------------------------------------------------------------
// Nearest-centre pixel quantiser, top level
// Classifies each pixel against the active stored centres by squared distance
// in a five-stage pipeline; load requests write the centre store directly.
// ----------------------------------------------------------------------------
module nearest_center_pixel_quantizer_top
	import ncpq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgBits-1:0]     cfg_data,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic                   req_type,
	input  logic [IdxBits-1:0]     center_index,
	input  logic [ChannelBits-1:0] chan_a,
	input  logic [ChannelBits-1:0] chan_b,
	input  logic [ChannelBits-1:0] chan_c,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [IdxBits-1:0]     label,
	output logic [ChannelBits-1:0] out_a,
	output logic [ChannelBits-1:0] out_b,
	output logic [ChannelBits-1:0] out_c,
	output logic [DistBits-1:0]    min_distance
);

	localparam int L1Nodes = MaxCenters / 2;
	localparam int L2Nodes = MaxCenters / 4;
	localparam int L3Nodes = MaxCenters / 8;

	logic [CfgBits-1:0] num_centers_q;
	pix_t               center_store_q [MaxCenters];

	pix_t               pix_in;
	logic [CfgBits-1:0] n_eff;
	logic               req_acc;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	pix_t                   pix_s1, pix_s2, pix_s3, pix_s4;
	pix_t                   diff_d  [MaxCenters];
	logic [NumChannels-1:0] neg_d   [MaxCenters];
	logic [MaxCenters-1:0]  act_d;
	pix_t                   diff_s1 [MaxCenters];
	logic [NumChannels-1:0] neg_s1  [MaxCenters];
	logic [MaxCenters-1:0]  act_s1;
	logic [SqBits-1:0]      sq_d    [MaxCenters][NumChannels];
	logic [SqBits-1:0]      sq_s2   [MaxCenters][NumChannels];
	pix_t                   diff_s2 [MaxCenters];
	logic [NumChannels-1:0] neg_s2  [MaxCenters];
	logic [MaxCenters-1:0]  act_s2;
	cand_t                  cand_d  [MaxCenters];
	cand_t                  cand_s3 [MaxCenters];
	cand_t                  lvl1    [L1Nodes];
	cand_t                  lvl2    [L2Nodes];
	cand_t                  cand_s4 [L2Nodes];
	cand_t                  lvl3    [L3Nodes];
	cand_t                  win_d;
	pix_t                   ctr_d;
	cand_t                  win_s5;
	pix_t                   ctr_s5;

	// Each stage may take new data when it is empty or its content moves on.
	assign rdy_s5    = !vld_s5 || rsp_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign req_ready = rdy_s1;
	assign req_acc   = req_valid && req_ready;

	assign pix_in[0] = chan_a;
	assign pix_in[1] = chan_b;
	assign pix_in[2] = chan_c;

	always_comb begin
		if (num_centers_q == '0) begin
			n_eff = CfgBits'(1);
		end else if (num_centers_q > CfgBits'(MaxCenters)) begin
			n_eff = CfgBits'(MaxCenters);
		end else begin
			n_eff = num_centers_q;
		end
	end

	// Stage 0: absolute differences against every stored centre, one lane each.
	always_comb begin
		for (int k = 0; k < MaxCenters; k++) begin
			act_d[k] = CfgBits'(k) < n_eff;
			for (int c = 0; c < NumChannels; c++) begin
				neg_d[k][c]  = pix_in[c] < center_store_q[k][c];
				diff_d[k][c] = neg_d[k][c] ? (center_store_q[k][c] - pix_in[c])
				                           : (pix_in[c] - center_store_q[k][c]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MaxCenters; k++) begin
			for (int c = 0; c < NumChannels; c++) begin
				sq_d[k][c] = SqBits'(diff_s1[k][c] * diff_s1[k][c]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MaxCenters; k++) begin
			cand_d[k].act     = act_s2[k];
			cand_d[k].idx     = IdxBits'(k);
			cand_d[k].diff    = diff_s2[k];
			cand_d[k].neg     = neg_s2[k];
			cand_d[k].sq_dist = '0;
			for (int c = 0; c < NumChannels; c++) begin
				cand_d[k].sq_dist = cand_d[k].sq_dist + DistBits'(sq_s2[k][c]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < L1Nodes; i++) begin
			lvl1[i] = pick_nearer(cand_s3[2*i], cand_s3[2*i+1]);
		end
		for (int i = 0; i < L2Nodes; i++) begin
			lvl2[i] = pick_nearer(lvl1[2*i], lvl1[2*i+1]);
		end
	end

	// Last two tree levels, then the winning centre colour is rebuilt from the pixel.
	always_comb begin
		for (int i = 0; i < L3Nodes; i++) begin
			lvl3[i] = pick_nearer(cand_s4[2*i], cand_s4[2*i+1]);
		end
		win_d = pick_nearer(lvl3[0], lvl3[1]);
		for (int c = 0; c < NumChannels; c++) begin
			ctr_d[c] = win_d.neg[c] ? (pix_s4[c] + win_d.diff[c]) : (pix_s4[c] - win_d.diff[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_centers_q <= CfgBits'(MaxCenters);
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			vld_s5        <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_centers_q <= cfg_data;
			end
			if (rdy_s1) begin
				vld_s1 <= req_acc && (req_type == REQ_PIXEL);
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req_type == REQ_LOAD)) begin
			center_store_q[center_index] <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_acc && (req_type == REQ_PIXEL)) begin
			pix_s1  <= pix_in;
			diff_s1 <= diff_d;
			neg_s1  <= neg_d;
			act_s1  <= act_d;
		end
		if (rdy_s2 && vld_s1) begin
			pix_s2  <= pix_s1;
			sq_s2   <= sq_d;
			diff_s2 <= diff_s1;
			neg_s2  <= neg_s1;
			act_s2  <= act_s1;
		end
		if (rdy_s3 && vld_s2) begin
			pix_s3  <= pix_s2;
			cand_s3 <= cand_d;
		end
		if (rdy_s4 && vld_s3) begin
			pix_s4  <= pix_s3;
			cand_s4 <= lvl2;
		end
		if (rdy_s5 && vld_s4) begin
			win_s5 <= win_d;
			ctr_s5 <= ctr_d;
		end
	end

	assign rsp_valid    = vld_s5;
	assign label        = win_s5.idx;
	assign out_a        = ctr_s5[0];
	assign out_b        = ctr_s5[1];
	assign out_c        = ctr_s5[2];
	assign min_distance = win_s5.sq_dist;

	// The winner always comes from an active lane, since lane 0 is always active.
	a_winner_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> win_s5.act)
		else $error("nearest centre taken from an inactive lane");

	a_label_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, label} < n_eff))
		else $error("label beyond the active centre count");

	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (min_distance <= DistBits'(DistMax)))
		else $error("distance above the largest possible sum of squares");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-centre pixel quantiser testbench
// Loads the centre store and streams pixel requests through the quantiser under
// several centre counts and handshake idling patterns. Every pixel result is
// compared field by field with a prediction kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
	import ncpq_pkg::*;

	localparam int PhaseCount  = 6;
	localparam int PhaseItems  = 75;
	localparam int HoldPhase   = 4;
	localparam int HoldCycles  = 200;
	localparam int CfgSettle   = 12;
	localparam int DrainCycles = 20;
	localparam int CycleLimit  = 300000;
	localparam int DistSat     = (1 << DistBits) - 1;

	typedef struct packed {
		logic [IdxBits-1:0]  label;
		chan_t               a;
		chan_t               b;
		chan_t               c;
		logic [DistBits-1:0] sq_dist;
	} match_t;

	class center_tracker;
		chan_t              store [MaxCenters][NumChannels];
		logic [CfgBits-1:0] active_cfg;
		match_t             awaited [$];
		int                 errors;

		function new();
			active_cfg = 5'd16;
			errors = 0;
			foreach (store[k, ch])
				store[k][ch] = '0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("mismatch: %s", msg);
		endtask

		function match_t nearest_center(chan_t a, chan_t b, chan_t c);
			chan_t  pix [NumChannels];
			int     n, d, best_d, gap;
			match_t m;
			pix[0] = a;
			pix[1] = b;
			pix[2] = c;
			n = active_cfg;
			if (n < 1)
				n = 1;
			if (n > MaxCenters)
				n = MaxCenters;
			best_d = -1;
			m = '0;
			for (int k = 0; k < n; k++) begin
				d = 0;
				for (int ch = 0; ch < NumChannels; ch++) begin
					gap = int'(pix[ch]) - int'(store[k][ch]);
					d += gap * gap;
				end
				// Strictly nearer only, so the lowest index keeps a tie.
				if (best_d < 0 || d < best_d) begin
					best_d = d;
					m.label = IdxBits'(k);
				end
			end
			if (best_d > DistSat)
				best_d = DistSat;
			m.a = store[m.label][0];
			m.b = store[m.label][1];
			m.c = store[m.label][2];
			m.sq_dist = DistBits'(best_d);
			return m;
		endfunction

		function void note_request(req_type_t kind, logic [IdxBits-1:0] idx,
				chan_t a, chan_t b, chan_t c);
			if (kind == REQ_LOAD) begin
				store[idx][0] = a;
				store[idx][1] = b;
				store[idx][2] = c;
			end else begin
				awaited.insert(awaited.size(), nearest_center(a, b, c));
			end
		endfunction

		task check_result(match_t got);
			match_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result label %0d with no pixel request pending", got.label));
				return;
			end
			want = awaited.pop_front();
			if (got.label !== want.label)
				report($sformatf("label %0d, expected %0d", got.label, want.label));
			if (got.a !== want.a)
				report($sformatf("out_a %0d, expected %0d", got.a, want.a));
			if (got.b !== want.b)
				report($sformatf("out_b %0d, expected %0d", got.b, want.b));
			if (got.c !== want.c)
				report($sformatf("out_c %0d, expected %0d", got.c, want.c));
			if (got.sq_dist !== want.sq_dist)
				report($sformatf("min_distance %0d, expected %0d", got.sq_dist, want.sq_dist));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CfgBits-1:0]     cfg_data;
	logic                   req_valid;
	logic                   req_ready;
	logic                   req_type;
	logic [IdxBits-1:0]     center_index;
	logic [ChannelBits-1:0] chan_a;
	logic [ChannelBits-1:0] chan_b;
	logic [ChannelBits-1:0] chan_c;
	logic                   rsp_valid;
	logic                   rsp_ready;
	logic [IdxBits-1:0]     label;
	logic [ChannelBits-1:0] out_a;
	logic [ChannelBits-1:0] out_b;
	logic [ChannelBits-1:0] out_c;
	logic [DistBits-1:0]    min_distance;

	center_tracker sb;
	int            snd_idle_pct;
	int            rcv_idle_pct;
	int            phase;
	int            cycles;

	nearest_center_pixel_quantizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.center_index (center_index),
		.chan_a       (chan_a),
		.chan_b       (chan_b),
		.chan_c       (chan_c),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.label        (label),
		.out_a        (out_a),
		.out_b        (out_b),
		.out_c        (out_c),
		.min_distance (min_distance)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Result side: checks accepted results and throttles rsp_ready.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result('{label, out_a, out_b, out_c, min_distance});
			// A long hold-off lets the pipeline fill so that the block stalls its input.
			if (phase == HoldPhase && !hold_done) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	task automatic send_request(req_type_t kind, logic [IdxBits-1:0] idx,
			chan_t a, chan_t b, chan_t c);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= kind;
		center_index <= idx;
		chan_a       <= a;
		chan_b       <= b;
		chan_c       <= c;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(kind, idx, a, b, c);
	endtask

	// Only written with the block idle: every result in and the pipeline drained.
	task automatic set_active_centers(logic [CfgBits-1:0] value);
		req_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (CfgSettle) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.active_cfg = value;
	endtask

	function automatic chan_t any_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	task automatic random_request();
		req_type_t          kind;
		logic [IdxBits-1:0] idx;
		chan_t              a, b, c;
		int                 src;
		kind = ($urandom_range(99) < 25) ? REQ_LOAD : REQ_PIXEL;
		idx = IdxBits'($urandom_range(MaxCenters - 1));
		a = any_channel();
		b = any_channel();
		c = any_channel();
		// Copying a stored centre gives exact hits for pixels and duplicate centres for loads.
		if ($urandom_range(99) < 15) begin
			src = $urandom_range(MaxCenters - 1);
			a = sb.store[src][0];
			b = sb.store[src][1];
			c = sb.store[src][2];
		end
		send_request(kind, idx, a, b, c);
	endtask

	initial begin
		chan_t ka;
		logic [CfgBits-1:0] cfg_val;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		req_valid    = 1'b0;
		req_type     = REQ_LOAD;
		center_index = '0;
		chan_a       = '0;
		chan_b       = '0;
		chan_c       = '0;
		snd_idle_pct = 34;
		rcv_idle_pct = 61;
		phase        = -1;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every entry first, so no pixel ever meets an unwritten centre.
		// Entry 9 repeats entry 5 to set up a tie.
		for (int k = 0; k < MaxCenters; k++) begin
			ka = (k == 9) ? 8'd85 : chan_t'(k * 17);
			send_request(REQ_LOAD, IdxBits'(k), ka, 8'd255 - ka,
				(k == 9 || k[0]) ? 8'd255 : 8'd0);
		end
		send_request(REQ_PIXEL, 4'd15, 8'd0, 8'd255, 8'd0);
		send_request(REQ_PIXEL, 4'd0, 8'd255, 8'd0, 8'd255);
		send_request(REQ_PIXEL, 4'd7, 8'd85, 8'd170, 8'd255);
		send_request(REQ_PIXEL, 4'd15, 8'd0, 8'd0, 8'd0);
		send_request(REQ_PIXEL, 4'd0, 8'd255, 8'd255, 8'd255);

		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0: cfg_val = 5'd1;
				1: cfg_val = 5'd0;
				2: cfg_val = 5'd31;
				3: cfg_val = 5'd16;
				4: cfg_val = CfgBits'($urandom_range(2, 15));
				default: cfg_val = CfgBits'($urandom_range(31));
			endcase
			set_active_centers(cfg_val);
			if (p < 2) begin
				snd_idle_pct = 34;
				rcv_idle_pct <= 61;
			end else if (p < 4) begin
				snd_idle_pct = 61;
				rcv_idle_pct <= 34;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct <= 0;
			end
			phase <= p;
			if (p == 0) begin
				// With a single active centre at the far corner the distance peaks.
				send_request(REQ_LOAD, 4'd0, 8'd255, 8'd255, 8'd255);
				send_request(REQ_PIXEL, 4'd9, 8'd0, 8'd0, 8'd0);
				send_request(REQ_PIXEL, 4'd3, 8'd255, 8'd255, 8'd255);
			end
			repeat (PhaseItems) random_request();
		end

		req_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- nearest_center_pixel_quantizer_top.f -----
rtl/core/ncpq_pkg.sv
rtl/core/nearest_center_pixel_quantizer_top.sv
tb/tb.sv
